/* rtl/sdsu_pkg.sv */
// Shared constants, codes and control types of the skyline drop and score unit.
package sdsu_pkg;

  localparam int SHEET_COLUMNS_DEF   = 1024;
  localparam int PROFILE_COLUMNS_DEF = 256;

  localparam int H_W     = 24;
  localparam int SH_W    = 23;
  localparam int COL_W   = 8;
  localparam int POS_W   = 10;
  localparam int REQ_W   = 2;
  localparam int SCORE_W = 40;
  localparam int DIV_W   = 64;

  localparam logic [SH_W-1:0] SHEET_HEIGHT_RST = 23'd256000;
  localparam int HUNDRED_Q8 = 25600;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_EVAL   = 2'd1,
    REQ_COMMIT = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DECODE,
    ST_CLR,
    ST_WALK1,
    ST_DRAIN1,
    ST_WALK2,
    ST_DRAIN2,
    ST_DIVA_GO,
    ST_DIVA_WAIT,
    ST_DIVB_GO,
    ST_DIVB_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic prof_wr;
    logic sky_clr;
    logic init;
    logic acc_init;
    logic walk_max;
    logic walk_scan;
    logic cnt_clr;
    logic cnt_inc;
    logic div_start;
    logic div_sel_b;
    logic lat_a;
    logic lat_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic oor;
    logic width_zero;
    logic cnt_last_sky;
    logic cnt_last_walk;
    logic pipe_busy;
    logic tw_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/sdsu_req_if.sv */
// Request channel: one beat carries one load, evaluate, commit or clear request.
interface sdsu_req_if;
  logic                                valid;
  logic                                ready;
  logic [sdsu_pkg::REQ_W-1:0]          req_type;
  logic [sdsu_pkg::COL_W-1:0]          column;
  logic signed [sdsu_pkg::H_W-1:0]     upper_height;
  logic signed [sdsu_pkg::H_W-1:0]     lower_height;
  logic                                last_column;
  logic [sdsu_pkg::POS_W-1:0]          position;

  modport source (
    output valid, req_type, column, upper_height, lower_height, last_column, position,
    input  ready
  );
  modport sink (
    input  valid, req_type, column, upper_height, lower_height, last_column, position,
    output ready
  );
endinterface

/* rtl/sdsu_rsp_if.sv */
// Result channel: one beat per request.
interface sdsu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdsu_pkg::H_W-1:0]     rest_offset;
  logic                                fits;
  logic signed [sdsu_pkg::SCORE_W-1:0] score;
  logic                                score_valid;
  logic                                out_of_range;

  modport source (
    output valid, rest_offset, fits, score, score_valid, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, rest_offset, fits, score, score_valid, out_of_range,
    output ready
  );
endinterface

/* rtl/skyline_drop_score_update_top.sv */
// Skyline drop and score unit: one request in, one result out. A load stores one profile
// column if it is in range, and a clear sweeps the skyline to zero. A commit walks the
// profile twice through the skyline and profile memories, draining the max pipeline after
// the first walk and the score pipeline after the second; an evaluate then also runs two
// divisions in the one shared bit-serial divider. An evaluate whose height sum is
// zero ends like a commit, and a placement off the sheet or an empty profile ends straight
// after decode. A result is loaded only once the previous one has left the output register.
// After reset the skyline is swept to zero before the first request is taken. A
// finished result waits in the output register while the next request is accepted.
module skyline_drop_score_update_top #(
  parameter int SHEET_COLUMNS   = sdsu_pkg::SHEET_COLUMNS_DEF,
  parameter int PROFILE_COLUMNS = sdsu_pkg::PROFILE_COLUMNS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sdsu_pkg::SH_W-1:0]   cfg_wdata_i,
  sdsu_req_if.sink                    req_i,
  sdsu_rsp_if.source                  rsp_o
);
  sdsu_pkg::cmd_t cmd;
  sdsu_pkg::sts_t sts;
  logic           in_ready;

  assign req_i.ready = in_ready;

  sdsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sdsu_dp #(
    .SHEET_COLUMNS   (SHEET_COLUMNS),
    .PROFILE_COLUMNS (PROFILE_COLUMNS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_i.req_type),
    .column_i       (req_i.column),
    .upper_height_i (req_i.upper_height),
    .lower_height_i (req_i.lower_height),
    .last_column_i  (req_i.last_column),
    .position_i     (req_i.position),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .rest_offset_o  (rsp_o.rest_offset),
    .fits_o         (rsp_o.fits),
    .score_o        (rsp_o.score),
    .score_valid_o  (rsp_o.score_valid),
    .out_of_range_o (rsp_o.out_of_range)
  );
endmodule

/* rtl/sdsu_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sdsu_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sdsu_pkg::DIV_W-1:0]   num_i,
  input  logic signed [sdsu_pkg::DIV_W-1:0]   den_i,
  output logic                                done_o,
  output logic signed [sdsu_pkg::DIV_W-1:0]   quo_o
);
  localparam int W   = sdsu_pkg::DIV_W;
  localparam int CW  = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  den_q;
  logic [W-1:0]  rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign ge     = rem_sh >= den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[W-1] ^ den_i[W-1];
      rem_q <= '0;
      quo_q <= num_i[W-1] ? W'(-num_i) : W'(num_i);
      den_q <= den_i[W-1] ? W'(-den_i) : W'(den_i);
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - den_q : rem_sh;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

/* rtl/sdsu_ctrl.sv */
// Sequencer: walks each request through its clear, scan, divide and result steps.
module sdsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdsu_pkg::sts_t      sts_i,
  output sdsu_pkg::cmd_t      cmd_o
);
  sdsu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sdsu_pkg::ST_INIT_CLR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sdsu_pkg::ST_INIT_CLR: if (sts_i.cnt_last_sky) state_d = sdsu_pkg::ST_IDLE;
      sdsu_pkg::ST_IDLE:     if (in_valid_i) state_d = sdsu_pkg::ST_DECODE;
      sdsu_pkg::ST_DECODE: begin
        case (sts_i.req)
          sdsu_pkg::REQ_LOAD:  state_d = sdsu_pkg::ST_FINISH;
          sdsu_pkg::REQ_CLEAR: state_d = sdsu_pkg::ST_CLR;
          default: begin
            if (sts_i.oor || sts_i.width_zero) state_d = sdsu_pkg::ST_FINISH;
            else                               state_d = sdsu_pkg::ST_WALK1;
          end
        endcase
      end
      sdsu_pkg::ST_CLR:    if (sts_i.cnt_last_sky) state_d = sdsu_pkg::ST_FINISH;
      sdsu_pkg::ST_WALK1:  if (sts_i.cnt_last_walk) state_d = sdsu_pkg::ST_DRAIN1;
      sdsu_pkg::ST_DRAIN1: if (!sts_i.pipe_busy) state_d = sdsu_pkg::ST_WALK2;
      sdsu_pkg::ST_WALK2:  if (sts_i.cnt_last_walk) state_d = sdsu_pkg::ST_DRAIN2;
      sdsu_pkg::ST_DRAIN2: begin
        if (!sts_i.pipe_busy) begin
          if (sts_i.req == sdsu_pkg::REQ_COMMIT || sts_i.tw_zero) begin
            state_d = sdsu_pkg::ST_FINISH;
          end else begin
            state_d = sdsu_pkg::ST_DIVA_GO;
          end
        end
      end
      sdsu_pkg::ST_DIVA_GO:   state_d = sdsu_pkg::ST_DIVA_WAIT;
      sdsu_pkg::ST_DIVA_WAIT: if (sts_i.div_done) state_d = sdsu_pkg::ST_DIVB_GO;
      sdsu_pkg::ST_DIVB_GO:   state_d = sdsu_pkg::ST_DIVB_WAIT;
      sdsu_pkg::ST_DIVB_WAIT: if (sts_i.div_done) state_d = sdsu_pkg::ST_FINISH;
      sdsu_pkg::ST_FINISH:    if (sts_i.out_free) state_d = sdsu_pkg::ST_IDLE;
      default:                state_d = sdsu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sdsu_pkg::ST_INIT_CLR, sdsu_pkg::ST_CLR: begin
        cmd_o.sky_clr = 1'b1;
        cmd_o.cnt_clr = sts_i.cnt_last_sky;
        cmd_o.cnt_inc = !sts_i.cnt_last_sky;
      end
      sdsu_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sdsu_pkg::ST_DECODE: begin
        cmd_o.cnt_clr = 1'b1;
        cmd_o.init    = 1'b1;
        cmd_o.prof_wr = (sts_i.req == sdsu_pkg::REQ_LOAD);
      end
      sdsu_pkg::ST_WALK1: begin
        cmd_o.walk_max = 1'b1;
        cmd_o.cnt_clr  = sts_i.cnt_last_walk;
        cmd_o.cnt_inc  = !sts_i.cnt_last_walk;
      end
      // the offset is final only once the max stage has drained
      sdsu_pkg::ST_DRAIN1: cmd_o.acc_init = !sts_i.pipe_busy;
      sdsu_pkg::ST_WALK2: begin
        cmd_o.walk_scan = 1'b1;
        cmd_o.cnt_clr   = sts_i.cnt_last_walk;
        cmd_o.cnt_inc   = !sts_i.cnt_last_walk;
      end
      sdsu_pkg::ST_DRAIN2:    ;
      sdsu_pkg::ST_DIVA_GO:   cmd_o.div_start = 1'b1;
      sdsu_pkg::ST_DIVA_WAIT: cmd_o.lat_a = sts_i.div_done;
      sdsu_pkg::ST_DIVB_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_b = 1'b1;
      end
      sdsu_pkg::ST_DIVB_WAIT: begin
        cmd_o.div_sel_b = 1'b1;
        cmd_o.lat_b     = sts_i.div_done;
      end
      sdsu_pkg::ST_FINISH: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end
endmodule

/* rtl/sdsu_dp.sv */
// Datapath: skyline and profile memories, scan pipeline, accumulators and result register.
module sdsu_dp #(
  parameter int SHEET_COLUMNS   = sdsu_pkg::SHEET_COLUMNS_DEF,
  parameter int PROFILE_COLUMNS = sdsu_pkg::PROFILE_COLUMNS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sdsu_pkg::SH_W-1:0]             cfg_wdata_i,
  input  logic [sdsu_pkg::REQ_W-1:0]            req_type_i,
  input  logic [sdsu_pkg::COL_W-1:0]            column_i,
  input  logic signed [sdsu_pkg::H_W-1:0]       upper_height_i,
  input  logic signed [sdsu_pkg::H_W-1:0]       lower_height_i,
  input  logic                                  last_column_i,
  input  logic [sdsu_pkg::POS_W-1:0]            position_i,
  input  sdsu_pkg::cmd_t                        cmd_i,
  output sdsu_pkg::sts_t                        sts_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sdsu_pkg::H_W-1:0]       rest_offset_o,
  output logic                                  fits_o,
  output logic signed [sdsu_pkg::SCORE_W-1:0]   score_o,
  output logic                                  score_valid_o,
  output logic                                  out_of_range_o
);
  localparam int HW     = sdsu_pkg::H_W;
  localparam int SKY_AW = $clog2(SHEET_COLUMNS);
  localparam int PA_W   = $clog2(PROFILE_COLUMNS);
  localparam int PW_W   = $clog2(PROFILE_COLUMNS + 1);
  localparam int CNT_W  = (SKY_AW > PW_W) ? SKY_AW : PW_W;
  localparam int EW     = HW + 2;        // scan arithmetic width
  localparam int PRW    = 2 * EW;        // product width
  localparam int TW_W   = 40;
  localparam int P_W    = 48;
  localparam int DW     = sdsu_pkg::DIV_W;
  localparam int SW     = sdsu_pkg::SCORE_W;

  localparam logic signed [HW:0] DMAX_INIT = -(HW+1)'(1 << (HW - 1));
  localparam logic signed [HW:0] H_MAX25   = (HW+1)'((1 << (HW - 1)) - 1);
  localparam logic signed [EW-1:0] H_MAXE  = EW'((1 << (HW - 1)) - 1);
  localparam logic signed [EW-1:0] H_MINE  = -EW'(1 << (HW - 1));
  localparam logic signed [DW:0] SC_MAX    = (DW+1)'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [DW:0] SC_MIN    = -(DW+1)'(64'd1 << (SW - 1));

  // configuration and latched request
  logic [sdsu_pkg::SH_W-1:0]       sheet_q;
  sdsu_pkg::req_e                  req_q;
  logic [sdsu_pkg::COL_W-1:0]      col_q;
  logic signed [HW-1:0]            up_q;
  logic signed [HW-1:0]            lo_q;
  logic                            last_q;
  logic [sdsu_pkg::POS_W-1:0]      x_q;
  logic [PW_W-1:0]                 width_q;
  logic [CNT_W-1:0]                cnt_q;

  // memories
  logic [HW-1:0]                   sky_mem [SHEET_COLUMNS];
  logic [2*HW-1:0]                 prof_mem [PROFILE_COLUMNS];
  logic [HW-1:0]                   sky_rd_q;
  logic [2*HW-1:0]                 prof_rd_q;
  logic [SKY_AW-1:0]               sky_ra;
  logic [SKY_AW-1:0]               sky_wa;
  logic [HW-1:0]                   sky_wd;
  logic                            sky_we;
  logic                            col_ok;

  // scan pipeline
  logic                            m1_q, s1_q, s2_q, s3_q;
  logic [SKY_AW-1:0]               a1_q;
  logic signed [HW:0]              dmax_q;
  logic signed [HW-1:0]            d_sat;
  logic                            fits_q;
  logic signed [EW-1:0]            dy_q, sm_q;
  logic signed [PRW-1:0]           prod_q;
  logic signed [DW-1:0]            s_q;
  logic signed [TW_W-1:0]          tw_q;
  logic signed [P_W-1:0]           p_q;
  logic signed [P_W-1:0]           pinit;
  logic signed [HW:0]              diff;
  logic signed [EW-1:0]            y0, y1, dy, sm, v, vmax, vmin;
  logic signed [HW-1:0]            ysat;
  logic signed [HW-1:0]            p_up, p_lo;
  logic                            commit_wr;

  // division and result
  logic signed [DW-1:0]            div_num, div_den, div_quo;
  logic                            div_done;
  logic signed [DW-1:0]            a_q, b_q;
  logic signed [DW:0]              score_sum;
  logic signed [SW-1:0]            score_sat;
  logic                            score_ok;
  logic [31:0]                     end_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       sheet_q <= sdsu_pkg::SHEET_HEIGHT_RST;
    else if (cfg_we_i) sheet_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= sdsu_pkg::req_e'(req_type_i);
      col_q  <= column_i;
      up_q   <= upper_height_i;
      lo_q   <= lower_height_i;
      last_q <= last_column_i;
      x_q    <= position_i;
    end
  end

  assign col_ok = 32'(col_q) < 32'(PROFILE_COLUMNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.prof_wr && col_ok && last_q) width_q <= PW_W'({1'b0, col_q} + 9'd1);
      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // profile memory: upper in the high half, lower in the low half
  always_ff @(posedge clk_i) begin
    if (cmd_i.prof_wr && col_ok) prof_mem[PA_W'(col_q)] <= {up_q, lo_q};
    prof_rd_q <= prof_mem[cnt_q[PA_W-1:0]];
  end

  assign sky_ra = SKY_AW'(32'(x_q) + 32'(cnt_q));
  assign sky_we = cmd_i.sky_clr || commit_wr;
  assign sky_wa = cmd_i.sky_clr ? cnt_q[SKY_AW-1:0] : a1_q;
  assign sky_wd = cmd_i.sky_clr ? '0 : ysat;

  always_ff @(posedge clk_i) begin
    if (sky_we) sky_mem[sky_wa] <= sky_wd;
    sky_rd_q <= sky_mem[sky_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= 1'b0;
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else begin
      m1_q <= cmd_i.walk_max;
      s1_q <= cmd_i.walk_scan;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  assign p_up = $signed(prof_rd_q[2*HW-1:HW]);
  assign p_lo = $signed(prof_rd_q[HW-1:0]);

  assign diff = (HW+1)'($signed(sky_rd_q)) - (HW+1)'(p_lo);
  assign d_sat = (dmax_q > H_MAX25) ? HW'(H_MAX25) :
                 (dmax_q < DMAX_INIT) ? HW'(DMAX_INIT) : HW'(dmax_q);

  assign y0   = EW'($signed(sky_rd_q));
  assign y1   = EW'(p_up) + EW'(d_sat);
  assign dy   = y1 - y0;
  assign sm   = y0 + y1;
  assign v    = EW'(p_lo) - y0;
  assign vmax = EW'(sdsu_pkg::HUNDRED_Q8) - EW'(d_sat);
  assign vmin = (v > vmax) ? vmax : v;
  assign ysat = (y1 > H_MAXE) ? HW'(H_MAXE) : (y1 < H_MINE) ? HW'(H_MINE) : HW'(y1);
  assign commit_wr = s1_q && (req_q == sdsu_pkg::REQ_COMMIT) && ($signed(sky_rd_q) < ysat);
  assign pinit = $signed(d_sat) * $signed({1'b0, width_q});

  always_ff @(posedge clk_i) begin
    a1_q <= sky_ra;
    if (cmd_i.init) begin
      dmax_q <= DMAX_INIT;
      fits_q <= 1'b1;
    end else if (m1_q && diff > dmax_q) begin
      dmax_q <= diff;
    end
    if (cmd_i.acc_init) begin
      p_q  <= pinit;
      tw_q <= '0;
      s_q  <= '0;
    end else begin
      if (s1_q) begin
        p_q  <= p_q + P_W'(vmin);
        tw_q <= tw_q + TW_W'(dy);
        if (y1 > $signed({3'b000, sheet_q})) fits_q <= 1'b0;
      end
      if (s3_q) s_q <= s_q + DW'(prod_q);
    end
    dy_q   <= dy;
    sm_q   <= sm;
    prod_q <= dy_q * sm_q;
  end

  // shared divider: first sum(dy*mid2)/(2*sum(dy)), then the lower-gap term over width
  assign div_num = cmd_i.div_sel_b ? DW'(p_q) : s_q;
  assign div_den = cmd_i.div_sel_b ? $signed(DW'({1'b0, width_q})) : (DW'(tw_q) <<< 1);

  sdsu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) a_q <= div_quo;
    if (cmd_i.lat_b) b_q <= div_quo;
  end

  assign score_sum = (DW+1)'(a_q) + (DW+1)'(b_q);
  assign score_sat = (score_sum > SC_MAX) ? SW'(SC_MAX) :
                     (score_sum < SC_MIN) ? SW'(SC_MIN) : SW'(score_sum);
  assign end_pos   = 32'(x_q) + 32'(width_q);
  assign score_ok  = (req_q == sdsu_pkg::REQ_EVAL) && (width_q != '0) && (tw_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rest_offset_o  <= '0;
      fits_o         <= 1'b0;
      score_o        <= '0;
      score_valid_o  <= 1'b0;
      out_of_range_o <= 1'b0;
      if (req_q == sdsu_pkg::REQ_EVAL || req_q == sdsu_pkg::REQ_COMMIT) begin
        if (sts_o.oor) begin
          out_of_range_o <= 1'b1;
        end else begin
          rest_offset_o <= d_sat;
          fits_o        <= fits_q;
          if (score_ok) begin
            score_o       <= score_sat;
            score_valid_o <= 1'b1;
          end
        end
      end
    end
  end

  assign sts_o.req           = req_q;
  assign sts_o.oor           = end_pos > 32'(SHEET_COLUMNS);
  assign sts_o.width_zero    = (width_q == '0);
  assign sts_o.cnt_last_sky  = (cnt_q == CNT_W'(SHEET_COLUMNS - 1));
  assign sts_o.cnt_last_walk = (cnt_q == CNT_W'(width_q) - CNT_W'(1));
  assign sts_o.pipe_busy     = m1_q || s1_q || s2_q || s3_q;
  assign sts_o.tw_zero       = (tw_q == '0);
  assign sts_o.div_done      = div_done;
  assign sts_o.out_free      = !out_valid_o || out_ready_i;
endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the skyline drop and score unit: a directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int NSKY  = 1024;
  localparam int NPROF = 256;
  localparam longint HMAX = 64'sd8388607;
  localparam longint HMIN = -64'sd8388608;

  typedef struct {
    sdsu_pkg::req_e        kind;
    logic [7:0]            col;
    logic signed [23:0]    up;
    logic signed [23:0]    lo;
    logic                  last;
    logic [9:0]            pos;
    bit                    known;
    logic signed [23:0]    e_off;
    logic                  e_fits;
    logic signed [39:0]    e_score;
    logic                  e_valid;
    logic                  e_oor;
  } req_row_t;

  typedef struct {
    logic signed [23:0] off;
    logic               fits;
    logic signed [39:0] score;
    logic               valid;
    logic               oor;
  } drop_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sdsu_pkg::SH_W-1:0] cfg_wdata_i = '0;
  bit quiet = 1'b0;
  int errors = 0;
  int n_items = 0, n_eval = 0, n_commit = 0, n_scored = 0, n_oor = 0, n_fit = 0;

  sdsu_req_if req_ch ();
  sdsu_rsp_if rsp_ch ();

  skyline_drop_score_update_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the unit
  logic signed [23:0] sky_h [NSKY];
  logic signed [23:0] prof_up [NPROF];
  logic signed [23:0] prof_lo [NPROF];
  bit                 prof_loaded [NPROF];
  int unsigned        prof_w;
  logic [sdsu_pkg::SH_W-1:0] sheet_h;

  drop_res_t pending_res [$];
  req_row_t  dir_rows [$];

  function automatic drop_res_t drop_and_score(input req_row_t r);
    drop_res_t res;
    longint d, v, y0, y1, dy, s, tw, p, vmax, sc;
    res = '{off: '0, fits: 1'b0, score: '0, valid: 1'b0, oor: 1'b0};
    if (r.kind == sdsu_pkg::REQ_LOAD) begin
      prof_up[r.col] = r.up;
      prof_lo[r.col] = r.lo;
      prof_loaded[r.col] = 1'b1;
      if (r.last) prof_w = r.col + 1;
    end else if (r.kind == sdsu_pkg::REQ_CLEAR) begin
      foreach (sky_h[i]) sky_h[i] = '0;
    end else if (int'(r.pos) + prof_w > NSKY) begin
      res.oor = 1'b1;
      n_oor++;
    end else begin
      d = HMIN;
      for (int i = 0; i < prof_w; i++) begin
        v = longint'(sky_h[r.pos + i]) - longint'(prof_lo[i]);
        if (v > d) d = v;
      end
      if (d > HMAX) d = HMAX;
      res.off = d[23:0];
      res.fits = 1'b1;
      for (int i = 0; i < prof_w; i++)
        if (longint'(prof_up[i]) + d > longint'(sheet_h)) res.fits = 1'b0;
      if (res.fits) n_fit++;
      if (r.kind == sdsu_pkg::REQ_EVAL && prof_w > 0) begin
        s = 0;
        tw = 0;
        p = d * prof_w;
        vmax = sdsu_pkg::HUNDRED_Q8 - d;
        for (int i = 0; i < prof_w; i++) begin
          y0 = sky_h[r.pos + i];
          y1 = longint'(prof_up[i]) + d;
          dy = y1 - y0;
          v = longint'(prof_lo[i]) - y0;
          s += dy * (y0 + y1);
          tw += dy;
          if (v > vmax) v = vmax;
          p += v;
        end
        if (tw != 0) begin
          sc = s / (2 * tw) + p / longint'(prof_w);
          if (sc > (64'sd1 <<< 39) - 1) sc = (64'sd1 <<< 39) - 1;
          if (sc < -(64'sd1 <<< 39)) sc = -(64'sd1 <<< 39);
          res.score = sc[39:0];
          res.valid = 1'b1;
          n_scored++;
        end
      end else if (r.kind == sdsu_pkg::REQ_COMMIT) begin
        for (int i = 0; i < prof_w; i++) begin
          y1 = longint'(prof_up[i]) + d;
          if (y1 > HMAX) y1 = HMAX;
          if (y1 < HMIN) y1 = HMIN;
          if (longint'(sky_h[r.pos + i]) < y1) sky_h[r.pos + i] = y1[23:0];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    drop_res_t w;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = pending_res.pop_front();
        if (rsp_ch.rest_offset !== w.off)
          report_mismatch("rest_offset", rsp_ch.rest_offset, w.off);
        if (rsp_ch.fits !== w.fits) report_mismatch("fits", rsp_ch.fits, w.fits);
        if (rsp_ch.score !== w.score) report_mismatch("score", rsp_ch.score, w.score);
        if (rsp_ch.score_valid !== w.valid)
          report_mismatch("score_valid", rsp_ch.score_valid, w.valid);
        if (rsp_ch.out_of_range !== w.oor)
          report_mismatch("out_of_range", rsp_ch.out_of_range, w.oor);
      end
    end
  end

  initial rsp_ch.ready = 1'b0;
  always @(negedge clk_i) rsp_ch.ready <= quiet || ($urandom_range(99) >= 20);

  task automatic send_beat(input req_row_t r);
    drop_res_t p;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.kind;
    req_ch.column       <= r.col;
    req_ch.upper_height <= r.up;
    req_ch.lower_height <= r.lo;
    req_ch.last_column  <= r.last;
    req_ch.position     <= r.pos;
    do @(posedge clk_i); while (!req_ch.ready);
    p = drop_and_score(r);
    if (r.kind == sdsu_pkg::REQ_EVAL) n_eval++;
    if (r.kind == sdsu_pkg::REQ_COMMIT) n_commit++;
    n_items++;
    if (r.known)
      pending_res.push_back('{off: r.e_off, fits: r.e_fits, score: r.e_score,
                              valid: r.e_valid, oor: r.e_oor});
    else
      pending_res.push_back(p);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_sheet_height(input logic [sdsu_pkg::SH_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sheet_h = val;
  endtask

  function automatic req_row_t mk(input sdsu_pkg::req_e k, input logic [7:0] c, input int u,
                                  input int l, input bit last, input int pos);
    req_row_t r;
    r = '{kind: k, col: c, up: u[23:0], lo: l[23:0], last: last, pos: pos[9:0], known: 1'b0,
          e_off: '0, e_fits: 1'b0, e_score: '0, e_valid: 1'b0, e_oor: 1'b0};
    return r;
  endfunction

  function automatic req_row_t with_exp(input req_row_t r, input int off, input bit f,
                                        input bit oor);
    r.known  = 1'b1;
    r.e_off  = off[23:0];
    r.e_fits = f;
    r.e_oor  = oor;
    return r;
  endfunction

  function automatic logic signed [23:0] pick_height();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return 24'($urandom_range(40000) - 8000);
    if (k < 85) return 24'($urandom);
    if (k < 92) return 24'sh7FFFFF;
    return 24'sh800000;
  endfunction

  function automatic bit profile_ready();
    for (int i = 0; i < prof_w; i++)
      if (!prof_loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_profile(input int w);
    for (int c = 0; c < w; c++)
      send_beat(mk(sdsu_pkg::REQ_LOAD, c[7:0], pick_height(), pick_height(), c == w - 1,
                   $urandom));
  endtask

  task automatic run_random(input int n);
    int stop, k, w;
    stop = n_items + n;
    while (n_items < stop) begin
      quiet = (n_items >= 400 && n_items < 550);
      k = $urandom_range(99);
      if (k < 8) begin
        k = $urandom_range(99);
        w = k < 85 ? $urandom_range(1, 12) : (k < 97 ? $urandom_range(13, 64)
                                                      : $urandom_range(200, 256));
        load_profile(w);
      end else if (k < 12) begin
        // stray load with random column and last flag
        send_beat(mk(sdsu_pkg::REQ_LOAD, 8'($urandom), pick_height(), pick_height(),
                     1'($urandom), $urandom));
      end else if (k < 14) begin
        send_beat(mk(sdsu_pkg::REQ_CLEAR, 8'($urandom), $urandom, $urandom, 1'($urandom),
                     $urandom));
      end else if (!profile_ready()) begin
        load_profile($urandom_range(1, 8));
      end else begin
        w = (k < 20) ? $urandom_range(1023) : $urandom_range(NSKY - prof_w);
        send_beat(mk((k & 1) ? sdsu_pkg::REQ_EVAL : sdsu_pkg::REQ_COMMIT, 8'($urandom),
                     $urandom, $urandom, 1'($urandom), w));
      end
    end
  endtask

  initial begin : timeout
    #100ms;
    $display("skyline_drop_score_update_top test failed");
    $finish;
  end

  initial begin : stim
    logic [sdsu_pkg::SH_W-1:0] sheet_vals [4];
    sheet_vals = '{23'd0, 23'h7FFFFF, 23'd40000, 23'd256000};
    req_ch.valid        = 1'b0;
    req_ch.req_type     = sdsu_pkg::REQ_LOAD;
    req_ch.column       = '0;
    req_ch.upper_height = '0;
    req_ch.lower_height = '0;
    req_ch.last_column  = 1'b0;
    req_ch.position     = '0;
    foreach (sky_h[i]) sky_h[i] = '0;
    foreach (prof_up[i]) begin
      prof_up[i] = '0;
      prof_lo[i] = '0;
      prof_loaded[i] = 1'b0;
    end
    prof_w  = 0;
    sheet_h = sdsu_pkg::SHEET_HEIGHT_RST;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 0), -8388608, 1, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_COMMIT, 0, 0, 0, 0, 1023), -8388608, 1, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_CLEAR, 8'hFF, -1, -1, 1, 1023), 0, 0, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_LOAD, 0, 25600, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_LOAD, 1, 8388607, -8388608, 1, 0), 0, 0, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 1022));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 1023), 0, 0, 1));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_COMMIT, 0, 0, 0, 0, 1023), 0, 0, 1));
    dir_rows.push_back(mk(sdsu_pkg::REQ_COMMIT, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_COMMIT, 0, 0, 0, 0, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_LOAD, 255, -8388608, 8388607, 0, 1023),
                                0, 0, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_LOAD, 0, 0, 0, 1, 0), 0, 0, 0));
    // flat profile on flat skyline: zero height sum, no score
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 5), 0, 1, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 0));
    dir_rows.push_back(with_exp(mk(sdsu_pkg::REQ_CLEAR, 0, 0, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 1023));
    dir_rows.push_back(mk(sdsu_pkg::REQ_LOAD, 0, 300000, 1000, 0, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_LOAD, 1, -500, -2000, 0, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_LOAD, 2, 4000, 3000, 1, 0));
    dir_rows.push_back(mk(sdsu_pkg::REQ_COMMIT, 0, 0, 0, 0, 100));
    dir_rows.push_back(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 99));
    dir_rows.push_back(mk(sdsu_pkg::REQ_EVAL, 0, 0, 0, 0, 1021));
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // hold until the unit has emptied
    wait_drained();
    run_random(150);
    wait_drained();
    run_random(150);
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_sheet_height(ph == 2 ? 23'($urandom_range(8388607)) : sheet_vals[ph]);
      run_random(ph == 3 ? 250 : 150);
    end
    wait_drained();

    $display("Ran %0d requests: %0d evaluates (%0d scored), %0d commits,", n_items, n_eval,
             n_scored, n_commit);
    $display("%0d placements off the sheet, %0d fitting drops.", n_oor, n_fit);
    if (errors == 0)
      $display("skyline_drop_score_update_top test passed");
    else
      $display("skyline_drop_score_update_top test failed");
    $finish;
  end

endmodule
